// File: rtl/core/btmx_pkg.sv
`timescale 1ns / 1ps

package btmx_pkg;

    // Default sizes of the trie
    localparam int KEY_BITS_DEF  = 32;
    localparam int MAX_NODES_DEF = 4096;

    // Fixed width of the key and result ports
    localparam int KEY_PORT_W = 32;

    // Operation codes on the op input
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_Q_WALK,
        ST_I_WALK,
        ST_I_CHECK,
        ST_I_ALLOC,
        ST_I_LEAF,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic q_step;
        logic i_walk;
        logic mark_full;
        logic alloc;
        logic leaf;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic hit;
        logic last;
        logic over;
        logic out_free;
    } status_t;

endpackage

// File: rtl/core/btmx_ram.sv
`timescale 1ns / 1ps

module btmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry with registered data
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/btmx_ctrl.sv
`timescale 1ns / 1ps

module btmx_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               op,
    input  btmx_pkg::status_t  status,
    output btmx_pkg::cmd_t     cmd,
    output logic               in_stall
);

    btmx_pkg::state_t state_reg;
    btmx_pkg::state_t state_next;

    // Advance the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= btmx_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            btmx_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (op == btmx_pkg::OP_QUERY)
                    begin
                        state_next = btmx_pkg::ST_Q_WALK;
                    end
                    else
                    begin
                        state_next = btmx_pkg::ST_I_WALK;
                    end
                end
            end
            btmx_pkg::ST_Q_WALK:
            begin
                if (status.last)
                begin
                    state_next = btmx_pkg::ST_DONE;
                end
            end
            btmx_pkg::ST_I_WALK:
            begin
                if (!status.hit)
                begin
                    state_next = btmx_pkg::ST_I_CHECK;
                end
                else if (status.last)
                begin
                    state_next = btmx_pkg::ST_DONE;
                end
            end
            btmx_pkg::ST_I_CHECK:
            begin
                if (status.over)
                begin
                    state_next = btmx_pkg::ST_DONE;
                end
                else
                begin
                    state_next = btmx_pkg::ST_I_ALLOC;
                end
            end
            btmx_pkg::ST_I_ALLOC:
            begin
                if (status.last)
                begin
                    state_next = btmx_pkg::ST_I_LEAF;
                end
            end
            btmx_pkg::ST_I_LEAF:
            begin
                state_next = btmx_pkg::ST_DONE;
            end
            btmx_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = btmx_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = btmx_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands for the datapath
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            btmx_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            btmx_pkg::ST_Q_WALK:
            begin
                cmd.q_step = 1'b1;
            end
            btmx_pkg::ST_I_WALK:
            begin
                cmd.i_walk = 1'b1;
            end
            btmx_pkg::ST_I_CHECK:
            begin
                cmd.mark_full = status.over;
            end
            btmx_pkg::ST_I_ALLOC:
            begin
                cmd.alloc = 1'b1;
            end
            btmx_pkg::ST_I_LEAF:
            begin
                cmd.leaf = 1'b1;
            end
            btmx_pkg::ST_DONE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// File: rtl/core/btmx_dpath.sv
`timescale 1ns / 1ps

module btmx_dpath #(
    parameter int KEY_BITS  = btmx_pkg::KEY_BITS_DEF,
    parameter int MAX_NODES = btmx_pkg::MAX_NODES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  btmx_pkg::cmd_t                  cmd,
    output btmx_pkg::status_t               status,
    input  logic                            op,
    input  logic [btmx_pkg::KEY_PORT_W-1:0] key,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [btmx_pkg::KEY_PORT_W-1:0] best_xor,
    output logic                            found,
    output logic                            full_res
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int UW = NW + 1;
    localparam int LW = $clog2(KEY_BITS + 1);
    localparam int EW = 2 + 2 * NW;

    // Walk registers
    logic [NW-1:0]       node_reg,    node_next;
    logic [LW-1:0]       left_reg,    left_next;
    logic [KEY_BITS-1:0] key_sh_reg,  key_sh_next;
    logic [KEY_BITS-1:0] best_reg,    best_next;
    logic                dead_reg,    dead_next;
    logic [EW-1:0]       entry_reg,   entry_next;
    logic                found_reg,   found_next;
    logic                full_reg,    full_next;

    // Pool state
    logic [UW-1:0]       used_reg,    used_next;
    logic [1:0]          root_reg,    root_next;

    // Output register
    logic                          out_valid_reg;
    logic [btmx_pkg::KEY_PORT_W-1:0] best_out_reg;
    logic                          found_out_reg;
    logic                          full_out_reg;

    // Node memory port
    logic          we;
    logic [NW-1:0] waddr;
    logic [EW-1:0] wdata;
    logic [EW-1:0] rdata;

    // Decode the current node
    logic          at_root;
    logic          bit_b;
    logic [1:0]    cur_present;
    logic [NW-1:0] cur_idx0;
    logic [NW-1:0] cur_idx1;
    logic          has_want;
    logic          has_b;
    logic [NW-1:0] fresh;
    logic [1:0]    bit_mask;
    logic [UW:0]   need_sum;

    btmx_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_NODES)
    ) u_node_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (node_next),
        .rdata (rdata)
    );

    assign at_root     = (left_reg == LW'(KEY_BITS));
    assign bit_b       = key_sh_reg[KEY_BITS-1];
    assign cur_present = dead_reg ? 2'b00 : (at_root ? root_reg : rdata[EW-1 -: 2]);
    assign cur_idx0    = rdata[NW-1:0];
    assign cur_idx1    = rdata[2*NW-1:NW];
    assign has_want    = cur_present[~bit_b];
    assign has_b       = cur_present[bit_b];
    assign fresh       = used_reg[NW-1:0];
    assign bit_mask    = bit_b ? 2'b10 : 2'b01;
    assign need_sum    = (UW+1)'(used_reg) + (UW+1)'(left_reg);

    // Report status to the controller
    assign status.hit      = has_b;
    assign status.last     = (left_reg == LW'(1));
    assign status.over     = (need_sum > (UW+1)'(MAX_NODES));
    assign status.out_free = !out_valid_reg || !out_stall;

    // Compute the next walk and pool values
    always_comb
    begin
        node_next   = node_reg;
        left_next   = left_reg;
        key_sh_next = key_sh_reg;
        best_next   = best_reg;
        dead_next   = dead_reg;
        entry_next  = entry_reg;
        found_next  = found_reg;
        full_next   = full_reg;
        used_next   = used_reg;
        root_next   = root_reg;
        we          = 1'b0;
        waddr       = node_reg;
        wdata       = '0;

        if (cmd.load)
        begin
            node_next   = '0;
            left_next   = LW'(KEY_BITS);
            key_sh_next = key[KEY_BITS-1:0];
            best_next   = '0;
            dead_next   = 1'b0;
            found_next  = (op == btmx_pkg::OP_QUERY) && (root_reg != 2'b00);
            full_next   = 1'b0;
        end

        // Query: prefer the opposite bit, else follow the same bit
        if (cmd.q_step)
        begin
            key_sh_next = key_sh_reg << 1;
            left_next   = left_reg - LW'(1);
            best_next   = (best_reg << 1) | KEY_BITS'(has_want);
            if (has_want)
            begin
                node_next = bit_b ? cur_idx0 : cur_idx1;
            end
            else if (has_b)
            begin
                node_next = bit_b ? cur_idx1 : cur_idx0;
            end
            else
            begin
                dead_next = 1'b1;
            end
        end

        // Insert: follow existing nodes, hold the node where the path ends
        if (cmd.i_walk)
        begin
            entry_next = {cur_present, cur_idx1, cur_idx0};
            if (has_b)
            begin
                node_next   = bit_b ? cur_idx1 : cur_idx0;
                key_sh_next = key_sh_reg << 1;
                left_next   = left_reg - LW'(1);
            end
        end

        if (cmd.mark_full)
        begin
            full_next = 1'b1;
        end

        // Link a fresh node under the current one
        if (cmd.alloc)
        begin
            we    = 1'b1;
            waddr = node_reg;
            wdata = {entry_reg[EW-1 -: 2] | bit_mask,
                     bit_b ? fresh : entry_reg[2*NW-1:NW],
                     bit_b ? entry_reg[NW-1:0] : fresh};
            if (at_root)
            begin
                root_next = root_reg | bit_mask;
            end
            node_next   = fresh;
            entry_next  = '0;
            used_next   = used_reg + UW'(1);
            left_next   = left_reg - LW'(1);
            key_sh_next = key_sh_reg << 1;
        end

        // Clear the leaf
        if (cmd.leaf)
        begin
            we    = 1'b1;
            waddr = node_reg;
            wdata = '0;
        end
    end

    // Hold pool state and output control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= UW'(1);
            root_reg      <= 2'b00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            root_reg <= root_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold walk payload and the result item
    always_ff @(posedge clk)
    begin
        node_reg   <= node_next;
        left_reg   <= left_next;
        key_sh_reg <= key_sh_next;
        best_reg   <= best_next;
        dead_reg   <= dead_next;
        entry_reg  <= entry_next;
        found_reg  <= found_next;
        full_reg   <= full_next;
        if (cmd.finish)
        begin
            best_out_reg  <= btmx_pkg::KEY_PORT_W'(best_reg);
            found_out_reg <= found_reg;
            full_out_reg  <= full_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign best_xor  = best_out_reg;
    assign found     = found_out_reg;
    assign full_res  = full_out_reg;

endmodule

// File: rtl/core/binary_trie_max_xor.sv
`timescale 1ns / 1ps
// Channel | Handshake            | Fields
// --------+----------------------+-------------------------------
// input   | in_valid / in_stall  | op, key
// output  | out_valid / out_stall| best_xor, found, full_res
//
// A query accepts the item, makes one dependent node-memory read per key bit and
// loads the output. A new-key insert walks to the first missing level, checks the
// pool, writes one node per missing level, clears the leaf and loads the output; if
// the pool lacks room, it sets full_res and loads the output after the check. A
// stored key is walked to its end. Reset clears the root's child flags and sets the
// node count to one; no clearing pass runs. A finished item waits in the output
// register while the next is worked on; a stalled result holds the next in DONE.

module binary_trie_max_xor #(
    parameter int KEY_BITS  = btmx_pkg::KEY_BITS_DEF,
    parameter int MAX_NODES = btmx_pkg::MAX_NODES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [btmx_pkg::KEY_PORT_W-1:0] key,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [btmx_pkg::KEY_PORT_W-1:0] best_xor,
    output logic                            found,
    output logic                            full_res
);

    btmx_pkg::cmd_t    cmd;
    btmx_pkg::status_t status;

    btmx_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    btmx_dpath #(
        .KEY_BITS  (KEY_BITS),
        .MAX_NODES (MAX_NODES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .op        (op),
        .key       (key),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .best_xor  (best_xor),
        .found     (found),
        .full_res  (full_res)
    );

endmodule
